### src/rotated_sprite_blitter_assert.svh
// ----------------------------------------------------------------------------
// Rotated sprite blitter assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef ROTATED_SPRITE_BLITTER_ASSERT_SVH
`define ROTATED_SPRITE_BLITTER_ASSERT_SVH

// Next-cycle implication, quiet while reset is held
`define RSB_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

// Next-cycle implication, also checked across reset
`define RSB_ASSERT_ALWAYS(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

### src/rsb_pkg.sv
// ----------------------------------------------------------------------------
// rsb_pkg
// Shared widths, register codes, control types and helpers of the blitter.
// ----------------------------------------------------------------------------
package rsb_pkg;

    // Default geometry
    localparam int SCREEN_WIDTH_DEF    = 1024;
    localparam int SCREEN_HEIGHT_DEF   = 768;
    localparam int PIXEL_BYTES_DEF     = 1;
    localparam int MAX_SPRITE_SIDE_DEF = 256;

    // Fixed constants of the blit
    localparam int FIXED_OFFSET = 20;
    localparam int MAX_COLOR    = 63;
    localparam int FRAC_W       = 14;

    // Field widths
    localparam int COLOR_W  = 8;
    localparam int FILL_W   = 6;
    localparam int OFFSET_W = 20;
    localparam int SIZE_W   = 9;
    localparam int ORIGIN_W = 16;
    localparam int TRIG_W   = 16;
    localparam int PAD_W    = 8;

    // Shared multiply-accumulate unit widths (cover sprite sides up to 1024)
    localparam int MUL_A_W = 14;
    localparam int MUL_B_W = 16;
    localparam int ACC_W   = 36;
    localparam int QUO_W   = ACC_W - FRAC_W;

    // Register port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_SPRITE_WIDTH  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SPRITE_HEIGHT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X      = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SINE          = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_COSINE        = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_PAD           = 3'd6;

    localparam int COSINE_RESET = 16384;

    // Accumulator base select
    localparam logic [1:0] BASE_ZERO = 2'd0;
    localparam logic [1:0] BASE_ACC  = 2'd1;
    localparam logic [1:0] BASE_LOAD = 2'd2;

    typedef struct packed {
        logic       acc_en;
        logic [1:0] base_sel;
        logic       negate;
    } t_mac_ctl;

    typedef struct packed {
        logic        [SIZE_W-1:0]   sprite_width;
        logic        [SIZE_W-1:0]   sprite_height;
        logic        [ORIGIN_W-1:0] origin_x;
        logic        [ORIGIN_W-1:0] origin_y;
        logic signed [TRIG_W-1:0]   sine_value;
        logic signed [TRIG_W-1:0]   cosine_value;
        logic        [PAD_W-1:0]    pad_distance;
    } t_cfg;

    // Divide by 2^FRAC_W, rounding toward zero
    function automatic logic signed [QUO_W-1:0] trunc_q(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] adj;
        adj = v[ACC_W-1] ? $signed(v + ACC_W'((1 << FRAC_W) - 1)) : v;
        return QUO_W'(adj >>> FRAC_W);
    endfunction

endpackage

### src/rsb_cfg.sv
// ----------------------------------------------------------------------------
// rsb_cfg
// Register file behind the APB-style configuration port.
// ----------------------------------------------------------------------------
module rsb_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rsb_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [rsb_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [rsb_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output rsb_pkg::t_cfg                   o_cfg
);
    import rsb_pkg::*;

    t_cfg                 r_cfg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite;
    assign o_cfg   = r_cfg;

    // Write the addressed register; drop writes beyond the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sprite_width  <= SIZE_W'(1);
            r_cfg.sprite_height <= SIZE_W'(1);
            r_cfg.origin_x      <= '0;
            r_cfg.origin_y      <= '0;
            r_cfg.sine_value    <= '0;
            r_cfg.cosine_value  <= TRIG_W'(COSINE_RESET);
            r_cfg.pad_distance  <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_SPRITE_WIDTH:  r_cfg.sprite_width  <= pwdata[SIZE_W-1:0];
                REG_SPRITE_HEIGHT: r_cfg.sprite_height <= pwdata[SIZE_W-1:0];
                REG_ORIGIN_X:      r_cfg.origin_x      <= pwdata[ORIGIN_W-1:0];
                REG_ORIGIN_Y:      r_cfg.origin_y      <= pwdata[ORIGIN_W-1:0];
                REG_SINE:          r_cfg.sine_value    <= $signed(pwdata[TRIG_W-1:0]);
                REG_COSINE:        r_cfg.cosine_value  <= $signed(pwdata[TRIG_W-1:0]);
                REG_PAD:           r_cfg.pad_distance  <= pwdata[PAD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        unique case (reg_idx)
            REG_SPRITE_WIDTH:  prdata = APB_DATA_W'(r_cfg.sprite_width);
            REG_SPRITE_HEIGHT: prdata = APB_DATA_W'(r_cfg.sprite_height);
            REG_ORIGIN_X:      prdata = APB_DATA_W'(r_cfg.origin_x);
            REG_ORIGIN_Y:      prdata = APB_DATA_W'(r_cfg.origin_y);
            REG_SINE:          prdata = APB_DATA_W'($unsigned(r_cfg.sine_value));
            REG_COSINE:        prdata = APB_DATA_W'($unsigned(r_cfg.cosine_value));
            REG_PAD:           prdata = APB_DATA_W'(r_cfg.pad_distance);
            default:           prdata = '0;
        endcase
    end

endmodule

### src/rsb_mac.sv
// ----------------------------------------------------------------------------
// rsb_mac
// Shared signed multiplier with a registered product and an accumulator.
// ----------------------------------------------------------------------------
module rsb_mac (
    input  logic                                    i_clk,
    input  logic signed [rsb_pkg::MUL_A_W-1:0]      i_mul_a,
    input  logic signed [rsb_pkg::MUL_B_W-1:0]      i_mul_b,
    input  rsb_pkg::t_mac_ctl                       i_ctl,
    input  logic signed [rsb_pkg::ACC_W-1:0]        i_preload,
    output logic signed [rsb_pkg::ACC_W-1:0]        o_acc
);
    import rsb_pkg::*;

    localparam int PROD_W = MUL_A_W + MUL_B_W;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  addend;
    logic signed [ACC_W-1:0]  base;
    logic signed [ACC_W-1:0]  n_acc;

    assign prod_ext = ACC_W'(r_prod);
    assign addend   = i_ctl.negate ? -prod_ext : prod_ext;
    assign o_acc    = r_acc;

    // Pick the accumulator base
    always_comb begin
        unique case (i_ctl.base_sel)
            BASE_ZERO: base = '0;
            BASE_ACC:  base = r_acc;
            BASE_LOAD: base = i_preload;
            default:   base = '0;
        endcase
        n_acc = base + addend;
    end

    // Register the product, then add the registered product into the accumulator when enabled
    always_ff @(posedge i_clk) begin
        r_prod <= i_mul_a * i_mul_b;
        if (i_ctl.acc_en) begin
            r_acc <= n_acc;
        end
    end

endmodule

### src/rotated_sprite_blitter.sv
// ----------------------------------------------------------------------------
// rotated_sprite_blitter
// Rotates sprite pixels about a pivot and emits frame-buffer byte offsets.
// ----------------------------------------------------------------------------
// Usage:
//   Pixel channel (i_pix_valid / o_pix_stall / i_pixel_color) takes sprite
//   pixels in row-major order; one beat per pixel. Result channel
//   (o_out_valid / i_out_stall / o_byte_offset / o_fill_color) gives one
//   beat per visible pixel; transparent or off-screen pixels give none.
//   One shared multiply-accumulate unit does all eight products of a pixel
//   in sequence, so o_pix_stall stays high from each accepted beat until
//   that pixel leaves its last step; a new pixel is taken only once the
//   last one is done. The result sits in an output register; while the
//   receiver stalls, the next pixel is still processed and waits in its
//   last step only if it too is visible and the register is still full.
//   Registers are to be written through the APB-style port only while the
//   block is idle; the block does not enforce this. Reset clears the
//   sprite counters, empties the output register and loads register
//   defaults (1x1 sprite, zero origin, no rotation).
// ----------------------------------------------------------------------------
module rotated_sprite_blitter #(
    parameter int SCREEN_WIDTH    = rsb_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT   = rsb_pkg::SCREEN_HEIGHT_DEF,
    parameter int PIXEL_BYTES     = rsb_pkg::PIXEL_BYTES_DEF,
    parameter int MAX_SPRITE_SIDE = rsb_pkg::MAX_SPRITE_SIDE_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rsb_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [rsb_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [rsb_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    // pixel channel
    input  logic                            i_pix_valid,
    output logic                            o_pix_stall,
    input  logic [rsb_pkg::COLOR_W-1:0]     i_pixel_color,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [rsb_pkg::OFFSET_W-1:0]    o_byte_offset,
    output logic [rsb_pkg::FILL_W-1:0]      o_fill_color
);
    import rsb_pkg::*;

    localparam int CW        = $clog2(MAX_SPRITE_SIDE);
    localparam int SIDE_W    = CW + 1;
    localparam int CMP_W     = (SIDE_W > SIZE_W) ? SIDE_W : SIZE_W;
    localparam int DX_W      = CW + 2;
    localparam int ROW_BYTES = SCREEN_WIDTH * PIXEL_BYTES;

    // Sequencer states
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_P0   = 4'd1;
    localparam logic [3:0] ST_P1   = 4'd2;
    localparam logic [3:0] ST_P2   = 4'd3;
    localparam logic [3:0] ST_P3   = 4'd4;
    localparam logic [3:0] ST_P4   = 4'd5;
    localparam logic [3:0] ST_P5   = 4'd6;
    localparam logic [3:0] ST_P6   = 4'd7;
    localparam logic [3:0] ST_P7   = 4'd8;
    localparam logic [3:0] ST_P8   = 4'd9;
    localparam logic [3:0] ST_P9   = 4'd10;
    localparam logic [3:0] ST_DONE = 4'd11;

    t_cfg cfg;

    logic [3:0]                 r_state, n_state;
    logic [CW-1:0]              r_col, n_col;
    logic [CW-1:0]              r_row, n_row;
    logic                       r_out_valid, n_out_valid;
    logic [COLOR_W-1:0]         r_color;
    logic signed [MUL_A_W-1:0]  r_dx;
    logic signed [MUL_A_W-1:0]  r_dy;
    logic signed [QUO_W-1:0]    r_rx;
    logic signed [QUO_W-1:0]    r_ry;
    logic signed [QUO_W-1:0]    r_sx;
    logic signed [QUO_W-1:0]    r_sy;
    logic [OFFSET_W-1:0]        r_byte_offset;
    logic [FILL_W-1:0]          r_fill_color;

    logic                       accept_in;
    logic                       out_free;
    logic                       visible;
    logic                       load_out;
    logic [SIDE_W-1:0]          w_eff;
    logic [SIDE_W-1:0]          h_eff;
    logic [CW-1:0]              half_w;
    logic signed [DX_W-1:0]     dx;
    logic signed [MUL_A_W-1:0]  push_len;
    logic signed [ACC_W-1:0]    acc;
    logic signed [ACC_W-1:0]    pre_x;
    logic signed [ACC_W-1:0]    pre_y;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [ACC_W-1:0]    preload;
    t_mac_ctl                   mac_ctl;

    // Clamp a configured side into 1..MAX_SPRITE_SIDE
    function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIZE_W-1:0] v);
        logic [SIDE_W-1:0] res;
        if (v == '0) begin
            res = SIDE_W'(1);
        end else if (CMP_W'(v) > CMP_W'(MAX_SPRITE_SIDE)) begin
            res = SIDE_W'(MAX_SPRITE_SIDE);
        end else begin
            res = SIDE_W'(v);
        end
        return res;
    endfunction

    rsb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rsb_mac u_mac (
        .i_clk     (i_clk),
        .i_mul_a   (mul_a),
        .i_mul_b   (mul_b),
        .i_ctl     (mac_ctl),
        .i_preload (preload),
        .o_acc     (acc)
    );

    // Handshake and sprite geometry
    assign o_pix_stall = (r_state != ST_IDLE);
    assign accept_in   = i_pix_valid & ~o_pix_stall;
    assign out_free    = ~r_out_valid | ~i_out_stall;
    assign w_eff       = clamp_side(cfg.sprite_width);
    assign h_eff       = clamp_side(cfg.sprite_height);
    assign half_w      = w_eff[SIDE_W-1:1];
    assign dx          = $signed({2'b00, r_col}) - $signed({2'b00, half_w});
    assign push_len    = MUL_A_W'(FIXED_OFFSET) + MUL_A_W'(cfg.pad_distance);
    assign pre_x       = (ACC_W'(r_rx) + $signed(ACC_W'(cfg.origin_x))) <<< FRAC_W;
    assign pre_y       = (ACC_W'(r_ry) + $signed(ACC_W'(cfg.origin_y))) <<< FRAC_W;

    // Visible: on screen and not transparent
    assign visible = !r_sx[QUO_W-1] && !r_sy[QUO_W-1]
                  && ($unsigned(r_sx) < QUO_W'(SCREEN_WIDTH))
                  && ($unsigned(r_sy) < QUO_W'(SCREEN_HEIGHT))
                  && (r_color <= COLOR_W'(MAX_COLOR));
    assign load_out = (r_state == ST_DONE) && visible && out_free;

    // Drive the shared unit for each step
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        mac_ctl = '0;
        preload = '0;
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept_in) begin
                    n_state = ST_P0;
                end
            end
            ST_P0: begin
                mul_a   = r_dx;
                mul_b   = cfg.cosine_value;
                n_state = ST_P1;
            end
            ST_P1: begin
                mul_a   = r_dy;
                mul_b   = cfg.sine_value;
                mac_ctl = '{acc_en: 1'b1, base_sel: BASE_ZERO, negate: 1'b0};
                n_state = ST_P2;
            end
            ST_P2: begin
                mul_a   = r_dx;
                mul_b   = cfg.sine_value;
                mac_ctl = '{acc_en: 1'b1, base_sel: BASE_ACC, negate: 1'b1};
                n_state = ST_P3;
            end
            ST_P3: begin
                mul_a   = r_dy;
                mul_b   = cfg.cosine_value;
                mac_ctl = '{acc_en: 1'b1, base_sel: BASE_ZERO, negate: 1'b0};
                n_state = ST_P4;
            end
            ST_P4: begin
                mul_a   = push_len;
                mul_b   = cfg.sine_value;
                mac_ctl = '{acc_en: 1'b1, base_sel: BASE_ACC, negate: 1'b0};
                n_state = ST_P5;
            end
            ST_P5: begin
                mul_a   = push_len;
                mul_b   = cfg.cosine_value;
                preload = pre_x;
                mac_ctl = '{acc_en: 1'b1, base_sel: BASE_LOAD, negate: 1'b1};
                n_state = ST_P6;
            end
            ST_P6: begin
                preload = pre_y;
                mac_ctl = '{acc_en: 1'b1, base_sel: BASE_LOAD, negate: 1'b0};
                n_state = ST_P7;
            end
            ST_P7: begin
                mul_a   = $signed(r_sx[MUL_A_W-1:0]);
                mul_b   = MUL_B_W'(PIXEL_BYTES);
                n_state = ST_P8;
            end
            ST_P8: begin
                mul_a   = $signed(r_sy[MUL_A_W-1:0]);
                mul_b   = MUL_B_W'(ROW_BYTES);
                mac_ctl = '{acc_en: 1'b1, base_sel: BASE_ZERO, negate: 1'b0};
                n_state = ST_P9;
            end
            ST_P9: begin
                mac_ctl = '{acc_en: 1'b1, base_sel: BASE_ACC, negate: 1'b0};
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!visible || out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Advance the column and row counters on each accepted pixel
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept_in) begin
            if ((SIDE_W'(r_col) + SIDE_W'(1)) >= w_eff) begin
                n_col = '0;
                if ((SIDE_W'(r_row) + SIDE_W'(1)) >= h_eff) begin
                    n_row = '0;
                end else begin
                    n_row = r_row + CW'(1);
                end
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    // Hold or drain the output register
    always_comb begin
        n_out_valid = r_out_valid;
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_col       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_row       <= n_row;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers: pixel operands, quotients, result
    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_color <= i_pixel_color;
            r_dx    <= MUL_A_W'(dx);
            r_dy    <= $signed(MUL_A_W'(r_row));
        end
        if (r_state == ST_P3) begin
            r_rx <= trunc_q(acc);
        end
        if (r_state == ST_P5) begin
            r_ry <= trunc_q(acc);
        end
        if (r_state == ST_P6) begin
            r_sx <= trunc_q(acc);
        end
        if (r_state == ST_P7) begin
            r_sy <= trunc_q(acc);
        end
        if (load_out) begin
            r_byte_offset <= acc[OFFSET_W-1:0];
            r_fill_color  <= r_color[FILL_W-1:0];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_byte_offset = r_byte_offset;
    assign o_fill_color  = r_fill_color;

endmodule

### src/rsb_checker.sv
// ----------------------------------------------------------------------------
// rsb_checker
// Port-level checks of the blitter, bound to the top level.
// ----------------------------------------------------------------------------
`include "rotated_sprite_blitter_assert.svh"

module rsb_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_pix_valid,
    input logic                            o_pix_stall,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic [rsb_pkg::OFFSET_W-1:0]    o_byte_offset,
    input logic [rsb_pkg::FILL_W-1:0]      o_fill_color
);
    // Reset empties the result register and frees the pixel side
    `RSB_ASSERT_ALWAYS(a_reset_clear, !i_rst_n, !o_out_valid && !o_pix_stall, "reset did not clear")

    // One pixel at a time: an accepted beat closes the pixel side
    `RSB_ASSERT_NEXT(a_single_item, i_pix_valid && !o_pix_stall, o_pix_stall, "second pixel taken while busy")

    // No result can appear right after a pixel is taken
    `RSB_ASSERT_NEXT(a_no_instant_result, i_pix_valid && !o_pix_stall, !$rose(o_out_valid), "result too early")

    // A stalled result beat holds
    `RSB_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_byte_offset) && $stable(o_fill_color), "stalled result changed")

endmodule

bind rotated_sprite_blitter rsb_checker u_rsb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_pix_valid   (i_pix_valid),
    .o_pix_stall   (o_pix_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_byte_offset (o_byte_offset),
    .o_fill_color  (o_fill_color)
);
